// ===== rtl/core/mme_pkg.sv =====
package mme_pkg;

    localparam int DIM_W  = 4;
    localparam int IDX_W  = 3;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int VAL_W  = 40;
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MAC   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             err;
        logic             mac_vld;
        logic             mac_first;
        logic             mac_done;
        logic             res_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_stat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_d);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > max_d) begin
            res = max_d;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/matrix_multiply_engine.sv =====
// Loading takes one item per cycle while busy is low and no register is written; an item
// with mismatched dimensions yields its error result on the next cycle. The last B item
// starts one shared MAC, one product per cycle; each product passes the memory read and
// product registers, results are registered, and busy stays high until the pipeline drains.
// Results are strobed for one cycle each and cannot be stalled.
// Synchronous reset restores all dimensions to 8 and restarts loading; stores are not cleared.
module matrix_multiply_engine #(
    parameter int MAX_DIM = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mme_pkg::CFG_AW-1:0]          paddr,
    input  logic [mme_pkg::CFG_DW-1:0]          pwdata,
    output logic [mme_pkg::CFG_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [mme_pkg::ELEM_W-1:0]   i_element_value,
    output logic                                o_valid,
    output logic signed [mme_pkg::VAL_W-1:0]    o_product_value,
    output logic [mme_pkg::IDX_W-1:0]           o_out_row,
    output logic [mme_pkg::IDX_W-1:0]           o_out_col,
    output logic                                o_last,
    output logic                                o_dim_error
);
    import mme_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
    logic             cfg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic [AW-1:0]    wr_addr, rd_a_addr, rd_b_addr;

    mme_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_a_rows (a_rows),
        .o_a_cols (a_cols),
        .o_b_rows (b_rows),
        .o_b_cols (b_cols),
        .o_cfg_wr (cfg_wr)
    );

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cfg_wr    (cfg_wr),
        .i_a_rows    (a_rows),
        .i_a_cols    (a_cols),
        .i_b_rows    (b_rows),
        .i_b_cols    (b_cols),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_a_addr (rd_a_addr),
        .o_rd_b_addr (rd_b_addr)
    );

    mme_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_wr_addr       (wr_addr),
        .i_rd_a_addr     (rd_a_addr),
        .i_rd_b_addr     (rd_b_addr),
        .i_element_value (i_element_value),
        .o_stat          (dp_stat),
        .o_valid         (o_valid),
        .o_product_value (o_product_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last          (o_last),
        .o_dim_error     (o_dim_error)
    );

endmodule

// ===== rtl/core/mme_regs.sv =====
module mme_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mme_pkg::CFG_AW-1:0]  paddr,
    input  logic [mme_pkg::CFG_DW-1:0]  pwdata,
    output logic [mme_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output logic [mme_pkg::DIM_W-1:0]   o_a_rows,
    output logic [mme_pkg::DIM_W-1:0]   o_a_cols,
    output logic [mme_pkg::DIM_W-1:0]   o_b_rows,
    output logic [mme_pkg::DIM_W-1:0]   o_b_cols,
    output logic                        o_cfg_wr
);
    import mme_pkg::*;

    logic [DIM_W-1:0] r_a_rows;
    logic [DIM_W-1:0] r_a_cols;
    logic [DIM_W-1:0] r_b_rows;
    logic [DIM_W-1:0] r_b_cols;
    logic [1:0]       reg_idx;
    logic [DIM_W-1:0] rd_val;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_RESET;
            r_a_cols <= DIM_RESET;
            r_b_rows <= DIM_RESET;
            r_b_cols <= DIM_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_A_ROWS: r_a_rows <= pwdata[DIM_W-1:0];
                REG_A_COLS: r_a_cols <= pwdata[DIM_W-1:0];
                REG_B_ROWS: r_b_rows <= pwdata[DIM_W-1:0];
                REG_B_COLS: r_b_cols <= pwdata[DIM_W-1:0];
                default:    r_a_rows <= r_a_rows;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_A_ROWS: rd_val = r_a_rows;
            REG_A_COLS: rd_val = r_a_cols;
            REG_B_ROWS: rd_val = r_b_rows;
            REG_B_COLS: rd_val = r_b_cols;
            default:    rd_val = '0;
        endcase
    end

    assign prdata   = CFG_DW'(rd_val);
    assign o_a_rows = r_a_rows;
    assign o_a_cols = r_a_cols;
    assign o_b_rows = r_b_rows;
    assign o_b_cols = r_b_cols;
    assign o_cfg_wr = wr_en;

endmodule

// ===== rtl/core/mme_ctrl.sv =====
module mme_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic                                    i_cfg_wr,
    input  logic [mme_pkg::DIM_W-1:0]               i_a_rows,
    input  logic [mme_pkg::DIM_W-1:0]               i_a_cols,
    input  logic [mme_pkg::DIM_W-1:0]               i_b_rows,
    input  logic [mme_pkg::DIM_W-1:0]               i_b_cols,
    input  mme_pkg::t_dp_stat                       i_stat,
    output mme_pkg::t_dp_cmd                        o_cmd,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_wr_addr,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_rd_a_addr,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_rd_b_addr
);
    import mme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = 2 * DIM_W;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_wptr, n_wptr;
    logic             r_phase_b, n_phase_b;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic [AW-1:0]    r_a_base, n_a_base;
    logic [AW-1:0]    r_b_addr, n_b_addr;

    logic [DIM_W-1:0] ar, ac, br, bc;
    logic [NW-1:0]    na, nb;
    logic [CW-1:0]    wptr_inc;
    logic             mismatch, accept, a_full, b_full;
    logic             i_end, j_end, k_end;

    always_comb begin
        ar       = clamp_dim(i_a_rows, DIM_W'(MAX_DIM));
        ac       = clamp_dim(i_a_cols, DIM_W'(MAX_DIM));
        br       = clamp_dim(i_b_rows, DIM_W'(MAX_DIM));
        bc       = clamp_dim(i_b_cols, DIM_W'(MAX_DIM));
        na       = NW'(ar) * NW'(ac);
        nb       = NW'(br) * NW'(bc);
        mismatch = (ac != br);
        accept   = i_start && (r_state == S_IDLE);
        wptr_inc = r_wptr + CW'(1);
        a_full   = (NW'(wptr_inc) == na);
        b_full   = (NW'(wptr_inc) == nb);
        i_end    = (DIM_W'(r_i) == ar - DIM_W'(1));
        j_end    = (DIM_W'(r_j) == bc - DIM_W'(1));
        k_end    = (DIM_W'(r_k) == ac - DIM_W'(1));
    end

    always_comb begin
        n_state   = r_state;
        n_wptr    = r_wptr;
        n_phase_b = r_phase_b;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_a_base  = r_a_base;
        n_b_addr  = r_b_addr;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_wr) begin
                    n_wptr    = '0;
                    n_phase_b = 1'b0;
                end else if (accept) begin
                    if (mismatch) begin
                        o_cmd.err = 1'b1;
                        n_wptr    = '0;
                        n_phase_b = 1'b0;
                    end else if (!r_phase_b) begin
                        o_cmd.wr_a = 1'b1;
                        if (a_full) begin
                            n_wptr    = '0;
                            n_phase_b = 1'b1;
                        end else begin
                            n_wptr = wptr_inc;
                        end
                    end else begin
                        o_cmd.wr_b = 1'b1;
                        if (b_full) begin
                            n_wptr    = '0;
                            n_phase_b = 1'b0;
                            n_state   = S_MAC;
                            n_i       = '0;
                            n_j       = '0;
                            n_k       = '0;
                            n_a_base  = '0;
                            n_b_addr  = '0;
                        end else begin
                            n_wptr = wptr_inc;
                        end
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_vld   = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                o_cmd.mac_done  = k_end;
                o_cmd.res_last  = i_end && j_end;
                o_cmd.row       = r_i;
                o_cmd.col       = r_j;
                if (!k_end) begin
                    n_k      = r_k + IDX_W'(1);
                    n_b_addr = r_b_addr + AW'(bc);
                end else begin
                    n_k = '0;
                    if (!j_end) begin
                        n_j      = r_j + IDX_W'(1);
                        n_b_addr = AW'(n_j);
                    end else begin
                        n_j      = '0;
                        n_b_addr = '0;
                        if (!i_end) begin
                            n_i      = r_i + IDX_W'(1);
                            n_a_base = r_a_base + AW'(ac);
                        end else begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wptr    <= '0;
            r_phase_b <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_a_base  <= '0;
            r_b_addr  <= '0;
        end else begin
            r_state   <= n_state;
            r_wptr    <= n_wptr;
            r_phase_b <= n_phase_b;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_a_base  <= n_a_base;
            r_b_addr  <= n_b_addr;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_wr_addr   = r_wptr[AW-1:0];
    assign o_rd_a_addr = r_a_base + AW'(r_k);
    assign o_rd_b_addr = r_b_addr;

endmodule

// ===== rtl/core/mme_dp.sv =====
module mme_dp #(
    parameter int MAX_DIM = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mme_pkg::t_dp_cmd                        i_cmd,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_wr_addr,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_rd_a_addr,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_rd_b_addr,
    input  logic signed [mme_pkg::ELEM_W-1:0]       i_element_value,
    output mme_pkg::t_dp_stat                       o_stat,
    output logic                                    o_valid,
    output logic signed [mme_pkg::VAL_W-1:0]        o_product_value,
    output logic [mme_pkg::IDX_W-1:0]               o_out_row,
    output logic [mme_pkg::IDX_W-1:0]               o_out_col,
    output logic                                    o_last,
    output logic                                    o_dim_error
);
    import mme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [ELEM_W-1:0] r_mem_a [DEPTH];
    logic signed [ELEM_W-1:0] r_mem_b [DEPTH];
    logic signed [ELEM_W-1:0] r_a_q;
    logic signed [ELEM_W-1:0] r_b_q;

    logic             r_s1_vld, r_s1_first, r_s1_done, r_s1_last;
    logic [IDX_W-1:0] r_s1_row, r_s1_col;
    logic             r_s2_vld, r_s2_first, r_s2_done, r_s2_last;
    logic [IDX_W-1:0] r_s2_row, r_s2_col;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  n_acc;

    logic                     r_out_vld;
    logic signed [VAL_W-1:0]  r_out_val;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic                     r_out_last, r_out_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_wr_addr] <= i_element_value;
        end
        r_a_q <= r_mem_a[i_rd_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_mem_b[i_wr_addr] <= i_element_value;
        end
        r_b_q <= r_mem_b[i_rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.mac_vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= i_cmd.err || (r_s2_vld && r_s2_done);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.mac_first;
        r_s1_done  <= i_cmd.mac_done;
        r_s1_last  <= i_cmd.res_last;
        r_s1_row   <= i_cmd.row;
        r_s1_col   <= i_cmd.col;
        r_s2_first <= r_s1_first;
        r_s2_done  <= r_s1_done;
        r_s2_last  <= r_s1_last;
        r_s2_row   <= r_s1_row;
        r_s2_col   <= r_s1_col;
        r_prod     <= r_a_q * r_b_q;
    end

    assign n_acc = r_s2_first ? VAL_W'(r_prod) : (r_acc + VAL_W'(r_prod));

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= n_acc;
        end
        if (i_cmd.err) begin
            r_out_val  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (r_s2_vld && r_s2_done) begin
            r_out_val  <= n_acc;
            r_out_row  <= r_s2_row;
            r_out_col  <= r_s2_col;
            r_out_last <= r_s2_last;
            r_out_err  <= 1'b0;
        end
    end

    assign o_stat.pipe_busy = r_s1_vld || r_s2_vld;
    assign o_valid          = r_out_vld;
    assign o_product_value  = r_out_val;
    assign o_out_row        = r_out_row;
    assign o_out_col        = r_out_col;
    assign o_last           = r_out_last;
    assign o_dim_error      = r_out_err;

endmodule

// ===== rtl/core/mme_checker.sv =====
module mme_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [mme_pkg::VAL_W-1:0]  o_product_value,
    input logic [mme_pkg::IDX_W-1:0]         o_out_row,
    input logic [mme_pkg::IDX_W-1:0]         o_out_col,
    input logic                              o_last,
    input logic                              o_dim_error
);
    import mme_pkg::*;

    // An error result is a single, final item with all payload cleared.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dim_error |->
            o_last && (o_product_value == '0) && (o_out_row == '0) && (o_out_col == '0))
        else $error("error result with non-zero payload");

    // The engine only becomes busy after it accepted an item.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // Product results only appear while a run is in progress.
    a_result_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dim_error |-> busy)
        else $error("product result outside a run");

    // The final product of a run releases the engine on the following cycle.
    a_last_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !o_dim_error |=> !busy)
        else $error("engine still busy after the final result");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_product_value (o_product_value),
    .o_out_row       (o_out_row),
    .o_out_col       (o_out_col),
    .o_last          (o_last),
    .o_dim_error     (o_dim_error)
);
